// ----- hw/rtl/atsc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Alarm time setting controller package
// Shared types and constants: commands, setting modes, periods, result layout.
// ----------------------------------------------------------------------------
package atsc_pkg;

   localparam int unsigned CmdWidth    = 3;
   localparam int unsigned HourWidth   = 5;
   localparam int unsigned MinuteWidth = 6;
   localparam int unsigned AlarmHourW  = 4;
   localparam int unsigned PeriodWidth = 2;
   localparam int unsigned ReqDataW    = 16;
   localparam int unsigned RspDataW    = 24;

   localparam logic [AlarmHourW-1:0]  HourLast   = 4'd11;
   localparam logic [MinuteWidth-1:0] MinuteLast = 6'd59;
   localparam logic [HourWidth-1:0]   HalfDay    = 5'd12;

   typedef enum logic [CmdWidth-1:0] {
      CMD_CHECK      = 3'd0,
      CMD_LIGHT_DOWN = 3'd1,
      CMD_ALARM_DOWN = 3'd2,
      CMD_ALARM_UP   = 3'd3,
      CMD_ALARM_LONG = 3'd4,
      CMD_ACTIVATE   = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_NONE   = 2'd0,
      MODE_HOUR   = 2'd1,
      MODE_MINUTE = 2'd2,
      MODE_PERIOD = 2'd3
   } mode_type;

   localparam logic [PeriodWidth-1:0] PERIOD_BOTH = 2'd0;
   localparam logic [PeriodWidth-1:0] PERIOD_AM   = 2'd1;
   localparam logic [PeriodWidth-1:0] PERIOD_PM   = 2'd2;

   // first member sits in the top bits, so mode_now lands at bit 0
   typedef struct packed {
      logic                   fast_tick;
      logic                   beep_request;
      logic                   led_request;
      logic                   alarm_match;
      logic                   alarm_enabled;
      logic [PeriodWidth-1:0] period_set;
      logic [MinuteWidth-1:0] minute_set;
      logic [AlarmHourW-1:0]  hour_set;
      logic [1:0]             mode_now;
   } rsp_fields_type;

endpackage
`default_nettype wire

// ----- hw/rtl/alarm_time_setting_controller.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Alarm time setting controller
// Setting-mode state machine, alarm time registers and time-match check.
// ----------------------------------------------------------------------------
// Items pass through the input register and then the result register on their
// way to rsp_tvalid. Throughput: one item per cycle while rsp_tready does not
// stall the result register; state update and result are combinational between.
// Reset (synchronous, active high) clears mode, alarm time, period and the
// on flag, empties both registers and sets button sound enable to 1.
module alarm_time_setting_controller (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: now_hour[4:0], now_minute[10:5], zero fill
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,
   // req_tuser: command[2:0]
   input  wire logic [2:0]  req_tuser,
   // rsp_tdata: mode_now[1:0], hour_set[5:2], minute_set[11:6], period_set[13:12],
   // alarm_enabled[14], alarm_match[15], led_request[16], beep_request[17],
   // fast_tick[18], zero fill
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_data
);

   // input register
   logic                                  in_valid_ff;
   atsc_pkg::cmd_type                     in_cmd_ff;
   logic [atsc_pkg::HourWidth-1:0]        in_hour_ff;
   logic [atsc_pkg::MinuteWidth-1:0]      in_minute_ff;

   // block state
   atsc_pkg::mode_type                    mode_ff, mode_in;
   logic [atsc_pkg::AlarmHourW-1:0]       hour_ff, hour_in;
   logic [atsc_pkg::MinuteWidth-1:0]      minute_ff, minute_in;
   logic [atsc_pkg::PeriodWidth-1:0]      period_ff, period_in;
   logic                                  on_ff, on_in;
   logic                                  sound_ff;

   // result register
   logic                                  rsp_valid_ff;
   atsc_pkg::rsp_fields_type              rsp_ff, rsp_in;

   logic advance;
   logic fire;
   logic match, led, beep;
   logic am_hit, pm_hit;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_cmd_ff    <= atsc_pkg::cmd_type'(req_tuser);
         in_hour_ff   <= req_tdata[4:0];
         in_minute_ff <= req_tdata[10:5];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sound_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         sound_ff <= csr_data;
      end
   end

   // next setting mode
   always_comb begin
      mode_in = mode_ff;
      case (in_cmd_ff)
         atsc_pkg::CMD_LIGHT_DOWN: begin
            case (mode_ff)
               atsc_pkg::MODE_HOUR:   mode_in = atsc_pkg::MODE_MINUTE;
               atsc_pkg::MODE_MINUTE: mode_in = atsc_pkg::MODE_PERIOD;
               atsc_pkg::MODE_PERIOD: mode_in = atsc_pkg::MODE_NONE;
               default:               mode_in = mode_ff;
            endcase
         end
         atsc_pkg::CMD_ALARM_LONG: begin
            if (mode_ff == atsc_pkg::MODE_NONE) begin
               mode_in = atsc_pkg::MODE_HOUR;
            end
         end
         atsc_pkg::CMD_ACTIVATE: mode_in = atsc_pkg::MODE_NONE;
         default:                mode_in = mode_ff;
      endcase
   end

   // alarm fields and request flags
   always_comb begin
      hour_in   = hour_ff;
      minute_in = minute_ff;
      period_in = period_ff;
      on_in     = on_ff;
      match     = 1'b0;
      led       = 1'b0;
      beep      = 1'b0;
      am_hit    = (period_ff != atsc_pkg::PERIOD_PM) &&
                  ({1'b0, hour_ff} == in_hour_ff);
      pm_hit    = (period_ff != atsc_pkg::PERIOD_AM) &&
                  (({1'b0, hour_ff} + atsc_pkg::HalfDay) == in_hour_ff);
      case (in_cmd_ff)
         atsc_pkg::CMD_CHECK: begin
            match = on_ff && (minute_ff == in_minute_ff) && (am_hit || pm_hit);
         end
         atsc_pkg::CMD_LIGHT_DOWN: begin
            case (mode_ff)
               atsc_pkg::MODE_NONE: led = 1'b1;
               atsc_pkg::MODE_PERIOD: begin
                  beep  = sound_ff;
                  on_in = 1'b1;
               end
               default: led = 1'b0;
            endcase
         end
         atsc_pkg::CMD_ALARM_DOWN: begin
            case (mode_ff)
               atsc_pkg::MODE_HOUR: begin
                  hour_in = (hour_ff >= atsc_pkg::HourLast) ? '0 : hour_ff + 1'b1;
               end
               atsc_pkg::MODE_MINUTE: begin
                  minute_in = (minute_ff >= atsc_pkg::MinuteLast) ? '0
                                                                 : minute_ff + 1'b1;
               end
               atsc_pkg::MODE_PERIOD: begin
                  period_in = (period_ff >= atsc_pkg::PERIOD_PM) ? atsc_pkg::PERIOD_BOTH
                                                                 : period_ff + 1'b1;
               end
               default: hour_in = hour_ff;
            endcase
         end
         atsc_pkg::CMD_ALARM_UP: begin
            if (mode_ff == atsc_pkg::MODE_NONE) begin
               on_in = !on_ff;
            end
         end
         atsc_pkg::CMD_ALARM_LONG: begin
            if (mode_ff == atsc_pkg::MODE_NONE) begin
               beep = sound_ff;
            end
         end
         default: match = 1'b0;
      endcase

      rsp_in.mode_now      = mode_in;
      rsp_in.hour_set      = hour_in;
      rsp_in.minute_set    = minute_in;
      rsp_in.period_set    = period_in;
      rsp_in.alarm_enabled = on_in;
      rsp_in.alarm_match   = match;
      rsp_in.led_request   = led;
      rsp_in.beep_request  = beep;
      rsp_in.fast_tick     = (mode_in != atsc_pkg::MODE_NONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= atsc_pkg::MODE_NONE;
         hour_ff   <= '0;
         minute_ff <= '0;
         period_ff <= atsc_pkg::PERIOD_BOTH;
         on_ff     <= 1'b0;
      end else if (fire) begin
         mode_ff   <= mode_in;
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         period_ff <= period_in;
         on_ff     <= on_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/atsc_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Alarm time setting controller checker
// Port-level checks on result items, bound to the top level.
// ----------------------------------------------------------------------------
module atsc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   a_fast_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[18] == (rsp_tdata[1:0] != 2'd0))
      else $error("fast_tick disagrees with mode");

   a_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[5:2] < 4'd12 && rsp_tdata[11:6] < 6'd60 &&
                     rsp_tdata[13:12] != 2'd3)
      else $error("alarm field out of range");

   a_led_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[16] |->
         rsp_tdata[1:0] == 2'd0 && !rsp_tdata[17] && !rsp_tdata[15])
      else $error("led request with other activity");

   a_beep_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[17] |->
         (rsp_tdata[1:0] == 2'd1) || (rsp_tdata[1:0] == 2'd0 && rsp_tdata[14]))
      else $error("beep outside hour entry or setting exit");

endmodule

bind alarm_time_setting_controller atsc_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Alarm time setting controller testbench
// Feeds button presses and time checks through the request stream, keeps its
// own model of the setting state machine and alarm registers, and compares
// every status item on the response stream field by field. Runs a directed
// pass, then random phases with different sound settings and idle patterns,
// including a long response hold-off that backs the block up.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic [atsc_pkg::CmdWidth-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [atsc_pkg::CmdWidth-1:0] CMD_SPARE_7 = 3'd7;
   localparam int LongHoldCycles = 300;
   localparam int PhaseItems     = 260;

   typedef struct {
      logic [atsc_pkg::CmdWidth-1:0]    cmd;
      logic [atsc_pkg::HourWidth-1:0]   hour;
      logic [atsc_pkg::MinuteWidth-1:0] minute;
   } press_type;

   typedef struct {
      atsc_pkg::mode_type               mode;
      logic [atsc_pkg::AlarmHourW-1:0]  hour;
      logic [atsc_pkg::MinuteWidth-1:0] minute;
      logic [atsc_pkg::PeriodWidth-1:0] period;
      logic                             on;
   } alarm_regs_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_data = 1'b0;

   alarm_time_setting_controller DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   press_type                button_presses[$];
   atsc_pkg::rsp_fields_type expected_status[$];
   alarm_regs_type           live_regs;     // follows accepted items
   alarm_regs_type           plan_regs;     // follows generated items, used to aim checks
   logic                     sound_on = 1'b1;
   int                       send_idle_pct = 0;
   int                       recv_stall_pct = 0;
   int                       hold_requests = 0;
   int                       holds_served = 0;
   int                       hold_left = 0;
   int                       mismatch_count = 0;
   int                       presses_made = 0;
   press_type                next_press;
   atsc_pkg::rsp_fields_type want_status;
   atsc_pkg::rsp_fields_type got_status;

   function automatic atsc_pkg::rsp_fields_type advance_alarm(
         inout alarm_regs_type s,
         input logic [atsc_pkg::CmdWidth-1:0] cmd,
         input logic [atsc_pkg::HourWidth-1:0] nh,
         input logic [atsc_pkg::MinuteWidth-1:0] nm,
         input logic sound);
      atsc_pkg::rsp_fields_type r;
      logic am_hit;
      logic pm_hit;
      r = '0;
      case (cmd)
         atsc_pkg::CMD_CHECK: begin
            am_hit = (s.period != atsc_pkg::PERIOD_PM) && ({1'b0, s.hour} == nh);
            pm_hit = (s.period != atsc_pkg::PERIOD_AM) &&
                     ({1'b0, s.hour} + atsc_pkg::HalfDay == nh);
            r.alarm_match = s.on && (s.minute == nm) && (am_hit || pm_hit);
         end
         atsc_pkg::CMD_LIGHT_DOWN: begin
            case (s.mode)
               atsc_pkg::MODE_NONE:   r.led_request = 1'b1;
               atsc_pkg::MODE_HOUR:   s.mode = atsc_pkg::MODE_MINUTE;
               atsc_pkg::MODE_MINUTE: s.mode = atsc_pkg::MODE_PERIOD;
               default: begin
                  // leaving period setting arms the alarm
                  s.mode = atsc_pkg::MODE_NONE;
                  s.on = 1'b1;
                  r.beep_request = sound;
               end
            endcase
         end
         atsc_pkg::CMD_ALARM_DOWN: begin
            case (s.mode)
               atsc_pkg::MODE_HOUR:
                  s.hour = (s.hour == atsc_pkg::HourLast) ? '0 : s.hour + 1'b1;
               atsc_pkg::MODE_MINUTE:
                  s.minute = (s.minute == atsc_pkg::MinuteLast) ? '0 : s.minute + 1'b1;
               atsc_pkg::MODE_PERIOD:
                  s.period = (s.period == atsc_pkg::PERIOD_PM) ? atsc_pkg::PERIOD_BOTH
                                                               : s.period + 1'b1;
               default: ;
            endcase
         end
         atsc_pkg::CMD_ALARM_UP: begin
            if (s.mode == atsc_pkg::MODE_NONE) s.on = ~s.on;
         end
         atsc_pkg::CMD_ALARM_LONG: begin
            if (s.mode == atsc_pkg::MODE_NONE) begin
               s.mode = atsc_pkg::MODE_HOUR;
               r.beep_request = sound;
            end
         end
         atsc_pkg::CMD_ACTIVATE: s.mode = atsc_pkg::MODE_NONE;
         default: ;
      endcase
      r.mode_now      = s.mode;
      r.hour_set      = s.hour;
      r.minute_set    = s.minute;
      r.period_set    = s.period;
      r.alarm_enabled = s.on;
      r.fast_tick     = (s.mode != atsc_pkg::MODE_NONE);
      return r;
   endfunction

   // ---------------- stimulus building ----------------

   task automatic add_press(input logic [atsc_pkg::CmdWidth-1:0] cmd,
                            input logic [atsc_pkg::HourWidth-1:0] nh,
                            input logic [atsc_pkg::MinuteWidth-1:0] nm);
      press_type p;
      p.cmd = cmd;
      p.hour = nh;
      p.minute = nm;
      button_presses.push_back(p);
      void'(advance_alarm(plan_regs, cmd, nh, nm, sound_on));
      presses_made++;
   endtask

   // time fields are don't-care for buttons, so keep them toggling
   task automatic add_button(input logic [atsc_pkg::CmdWidth-1:0] cmd);
      add_press(cmd, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
   endtask

   task automatic add_check();
      logic [atsc_pkg::HourWidth-1:0]   nh;
      logic [atsc_pkg::MinuteWidth-1:0] nm;
      nh = 5'($urandom_range(0, 23));
      nm = 6'($urandom_range(0, 59));
      if ($urandom_range(0, 9) == 0) begin
         nh = 5'($urandom_range(0, 31));
         nm = 6'($urandom_range(0, 63));
      end else if ($urandom_range(0, 2) != 0) begin
         // aim at the programmed alarm time, sometimes in the wrong half
         nm = plan_regs.minute;
         nh = {1'b0, plan_regs.hour};
         if (plan_regs.period == atsc_pkg::PERIOD_PM ||
             (plan_regs.period == atsc_pkg::PERIOD_BOTH && $urandom_range(0, 1)) ||
             $urandom_range(0, 5) == 0)
            nh = nh + atsc_pkg::HalfDay;
         if ($urandom_range(0, 7) == 0) nm = nm + 1'b1;
      end
      add_press(atsc_pkg::CMD_CHECK, nh, nm);
   endtask

   task automatic add_noise();
      logic [atsc_pkg::CmdWidth-1:0] cmd;
      cmd = 3'($urandom_range(atsc_pkg::CMD_CHECK, CMD_SPARE_7));
      if (cmd == atsc_pkg::CMD_CHECK) add_check();
      else add_button(cmd);
   endtask

   task automatic add_setting_run();
      int presses;
      int stage;
      add_button(atsc_pkg::CMD_ALARM_LONG);
      for (stage = 0; stage < 3; stage++) begin
         case (stage)
            0:       presses = $urandom_range(0, 13);
            1:       presses = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 61)
                                                           : $urandom_range(0, 5);
            default: presses = $urandom_range(0, 4);
         endcase
         repeat (presses) begin
            if ($urandom_range(0, 24) == 0) add_noise();
            add_button(atsc_pkg::CMD_ALARM_DOWN);
         end
         if ($urandom_range(0, 11) == 0) begin
            add_button(atsc_pkg::CMD_ACTIVATE);
            return;
         end
         add_button(atsc_pkg::CMD_LIGHT_DOWN);
      end
   endtask

   task automatic build_random(input int count);
      int goal;
      int pick;
      goal = presses_made + count;
      while (presses_made < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            add_setting_run();
         end else if (pick < 85) begin
            if ($urandom_range(0, 3) == 0) add_button(atsc_pkg::CMD_ALARM_UP);
            if ($urandom_range(0, 5) == 0) add_button(atsc_pkg::CMD_LIGHT_DOWN);
            repeat ($urandom_range(1, 6)) add_check();
         end else begin
            repeat ($urandom_range(1, 4)) add_noise();
         end
      end
   endtask

   // ---------------- phase control ----------------

   task automatic wait_drained();
      @(negedge clock);
      while (button_presses.size() != 0 || req_tvalid || expected_status.size() != 0)
         @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_sound(input logic value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sound_on = value;
      @(negedge clock);
   endtask

   task automatic note_mismatch(input string what, input int unsigned expv,
                                input int unsigned actv);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch on %s: expected %0d, got %0d", what, expv, actv);
   endtask

   task automatic compare_status(input atsc_pkg::rsp_fields_type want,
                                 input atsc_pkg::rsp_fields_type got);
      if (want.mode_now != got.mode_now)
         note_mismatch("mode_now", 32'(want.mode_now), 32'(got.mode_now));
      if (want.hour_set != got.hour_set)
         note_mismatch("hour_set", 32'(want.hour_set), 32'(got.hour_set));
      if (want.minute_set != got.minute_set)
         note_mismatch("minute_set", 32'(want.minute_set), 32'(got.minute_set));
      if (want.period_set != got.period_set)
         note_mismatch("period_set", 32'(want.period_set), 32'(got.period_set));
      if (want.alarm_enabled != got.alarm_enabled)
         note_mismatch("alarm_enabled", 32'(want.alarm_enabled), 32'(got.alarm_enabled));
      if (want.alarm_match != got.alarm_match)
         note_mismatch("alarm_match", 32'(want.alarm_match), 32'(got.alarm_match));
      if (want.led_request != got.led_request)
         note_mismatch("led_request", 32'(want.led_request), 32'(got.led_request));
      if (want.beep_request != got.beep_request)
         note_mismatch("beep_request", 32'(want.beep_request), 32'(got.beep_request));
      if (want.fast_tick != got.fast_tick)
         note_mismatch("fast_tick", 32'(want.fast_tick), 32'(got.fast_tick));
   endtask

   // ---------------- clock, driver, receiver, monitor ----------------

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_status.push_back(advance_alarm(live_regs, req_tuser,
                                                    req_tdata[4:0], req_tdata[10:5],
                                                    sound_on));
         if (!req_tvalid || req_tready) begin
            if (button_presses.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_press = button_presses.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= next_press.cmd;
               req_tdata  <= {5'b0, next_press.minute, next_press.hour};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (holds_served != hold_requests) begin
         hold_left    <= LongHoldCycles;
         holds_served <= holds_served + 1;
         rsp_tready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_status = atsc_pkg::rsp_fields_type'(
                         rsp_tdata[$bits(atsc_pkg::rsp_fields_type)-1:0]);
         if (expected_status.size() == 0) begin
            note_mismatch("unexpected item (raw tdata)", 0, 32'(rsp_tdata));
         end else begin
            want_status = expected_status.pop_front();
            compare_status(want_status, got_status);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // ---------------- test sequence ----------------

   initial begin
      live_regs = '{atsc_pkg::MODE_NONE, '0, '0, atsc_pkg::PERIOD_BOTH, 1'b0};
      plan_regs = live_regs;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed pass, sound enabled from reset
      add_press(atsc_pkg::CMD_CHECK, 5'd0, 6'd0);  // alarm off: no match
      add_button(atsc_pkg::CMD_ALARM_UP);          // toggle on
      add_press(atsc_pkg::CMD_CHECK, 5'd0, 6'd0);  // AM half match
      add_press(atsc_pkg::CMD_CHECK, 5'd12, 6'd0); // PM half match
      add_press(atsc_pkg::CMD_CHECK, 5'd31, 6'd63); // out of range, never matches
      add_button(atsc_pkg::CMD_LIGHT_DOWN);        // backlight
      add_button(atsc_pkg::CMD_ALARM_DOWN);        // no effect in normal mode
      add_button(CMD_SPARE_6);
      add_button(CMD_SPARE_7);
      add_button(atsc_pkg::CMD_ALARM_LONG);        // enter hour setting, beep
      add_button(atsc_pkg::CMD_ALARM_LONG);        // ignored while setting
      add_button(atsc_pkg::CMD_ALARM_UP);          // ignored while setting
      add_button(atsc_pkg::CMD_ALARM_DOWN);
      add_button(atsc_pkg::CMD_LIGHT_DOWN);
      add_button(atsc_pkg::CMD_ALARM_DOWN);
      add_button(atsc_pkg::CMD_LIGHT_DOWN);
      add_button(atsc_pkg::CMD_ALARM_DOWN);        // AM only
      add_button(atsc_pkg::CMD_ACTIVATE);          // drop out, alarm stays on
      add_press(atsc_pkg::CMD_CHECK, 5'd1, 6'd1);
      add_press(atsc_pkg::CMD_CHECK, 5'd13, 6'd1); // PM half excluded
      add_button(atsc_pkg::CMD_ALARM_UP);          // toggle off
      add_press(atsc_pkg::CMD_CHECK, 5'd1, 6'd1);
      add_button(atsc_pkg::CMD_ALARM_LONG);
      add_button(atsc_pkg::CMD_LIGHT_DOWN);
      add_button(atsc_pkg::CMD_LIGHT_DOWN);
      add_button(atsc_pkg::CMD_LIGHT_DOWN);        // leave period setting: on, beep
      wait_drained();

      write_sound(1'b0);
      build_random(PhaseItems);
      wait_drained();

      write_sound(1'b1);
      send_idle_pct = 83;
      build_random(PhaseItems);
      wait_drained();

      write_sound(1'b0);
      send_idle_pct  = 0;
      recv_stall_pct = 83;
      build_random(PhaseItems);
      wait_drained();

      write_sound(1'b1);
      send_idle_pct  = 37;
      recv_stall_pct = 37;
      build_random(PhaseItems);
      wait_drained();

      // back-pressure: hold the response side while requests keep coming
      write_sound(1'b0);
      send_idle_pct  = 0;
      recv_stall_pct = 20;
      build_random(PhaseItems / 2);
      hold_requests++;
      wait_drained();
      build_random(PhaseItems / 2);
      hold_requests++;
      wait_drained();

      repeat (5) @(posedge clock);
      if (mismatch_count == 0 && expected_status.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/atsc_pkg.sv
hw/rtl/alarm_time_setting_controller.sv
hw/rtl/atsc_checker.sv
tb/testbench.sv
